@@ design/base32_group_decoder_assert.svh @@
// ----------------------------------------------------------------------------
// base32_group_decoder assertion macros
// Shared concurrent assertion forms used by the decoder's checker.
// ----------------------------------------------------------------------------
`ifndef BASE32_GROUP_DECODER_ASSERT_SVH
`define BASE32_GROUP_DECODER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off while in reset.
`define B32GD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("base32_group_decoder: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock, off while in reset.
`define B32GD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("base32_group_decoder: next-cycle check failed");

`endif

@@ design/b32gd_pkg.sv @@
// ----------------------------------------------------------------------------
// b32gd_pkg
// Types and constants shared by the Base32 group decoder modules.
// ----------------------------------------------------------------------------
package b32gd_pkg;

    // Width of the saturating message byte counter (8 to 32).
    localparam int TOTAL_WIDTH = 16;

    localparam int NUM_LANES   = 8;
    localparam int MSG_WIDTH   = 16;

    localparam logic [7:0] CODE_PAD = 8'h3D;

    typedef struct packed {
        logic [7:0] char_0;
        logic [7:0] char_1;
        logic [7:0] char_2;
        logic [7:0] char_3;
        logic [7:0] char_4;
        logic [7:0] char_5;
        logic [7:0] char_6;
        logic [7:0] char_7;
        logic       last_group;
    } t_in_req;

    typedef struct packed {
        logic [7:0]           byte_0;
        logic [7:0]           byte_1;
        logic [7:0]           byte_2;
        logic [7:0]           byte_3;
        logic [7:0]           byte_4;
        logic [2:0]           valid_bytes;
        logic                 group_error;
        logic [MSG_WIDTH-1:0] message_bytes;
        logic                 message_error;
    } t_out_req;

    // What one lane reports about its character.
    typedef struct packed {
        logic [4:0] value;   // symbol value, zero for padding and bad codes
        logic       is_sym;
        logic       is_pad;
    } t_sym;

endpackage

@@ design/b32gd_lane.sv @@
// ----------------------------------------------------------------------------
// b32gd_lane
// Classifies one ASCII code as a Base32 symbol, padding, or invalid.
// ----------------------------------------------------------------------------
module b32gd_lane (
    input  logic [7:0]        i_code,
    output b32gd_pkg::t_sym   o_sym
);

    logic is_upper;
    logic is_lower;
    logic is_digit;
    logic [7:0] letter_off;
    logic [7:0] digit_off;

    assign is_upper = (i_code >= 8'h41) && (i_code <= 8'h5A);
    assign is_lower = (i_code >= 8'h61) && (i_code <= 8'h7A);
    assign is_digit = (i_code >= 8'h32) && (i_code <= 8'h37);

    // Upper and lower case differ only in bit 5, so one offset serves both.
    assign letter_off = {3'b010, i_code[4:0]} - 8'h41;
    assign digit_off  = i_code - 8'h32 + 8'd26;

    always_comb begin
        o_sym        = '0;
        o_sym.is_pad = (i_code == b32gd_pkg::CODE_PAD);
        if (is_upper || is_lower) begin
            o_sym.value  = letter_off[4:0];
            o_sym.is_sym = 1'b1;
        end else if (is_digit) begin
            o_sym.value  = digit_off[4:0];
            o_sym.is_sym = 1'b1;
        end
    end

endmodule

@@ design/b32gd_merge.sv @@
// ----------------------------------------------------------------------------
// b32gd_merge
// Combines the eight lane results into bytes, count and message totals.
// ----------------------------------------------------------------------------
module b32gd_merge (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_accept,
    input  b32gd_pkg::t_sym [b32gd_pkg::NUM_LANES-1:0]    i_syms,
    input  logic                                          i_last_group,
    output b32gd_pkg::t_out_req                           o_result
);

    localparam int TW = b32gd_pkg::TOTAL_WIDTH;

    logic [TW-1:0] r_total;
    logic          r_error_seen;
    logic [TW-1:0] n_total;
    logic          n_error_seen;

    logic          bad;
    logic [2:0]    nvalid;
    logic [TW:0]   sum;
    logic [TW-1:0] sat_total;
    logic          err_now;
    logic [31:0]   total_ext;
    logic [4:0]    v0, v1, v2, v3, v4, v5, v6, v7;

    assign v0 = i_syms[0].value;
    assign v1 = i_syms[1].value;
    assign v2 = i_syms[2].value;
    assign v3 = i_syms[3].value;
    assign v4 = i_syms[4].value;
    assign v5 = i_syms[5].value;
    assign v6 = i_syms[6].value;
    assign v7 = i_syms[7].value;

    // The first two characters must be symbols; the rest may also be padding.
    always_comb begin
        bad = !i_syms[0].is_sym || !i_syms[1].is_sym;
        for (int i = 2; i < b32gd_pkg::NUM_LANES; i++) begin
            if (!i_syms[i].is_sym && !i_syms[i].is_pad) begin
                bad = 1'b1;
            end
        end
    end

    always_comb begin
        if (bad) begin
            nvalid = 3'd0;
        end else if (!i_syms[7].is_pad) begin
            nvalid = 3'd5;
        end else if (!i_syms[5].is_pad) begin
            nvalid = 3'd4;
        end else if (!i_syms[4].is_pad) begin
            nvalid = 3'd3;
        end else if (!i_syms[2].is_pad) begin
            nvalid = 3'd2;
        end else begin
            nvalid = 3'd1;
        end
    end

    assign sum       = {1'b0, r_total} + {{(TW-2){1'b0}}, nvalid};
    assign sat_total = sum[TW] ? {TW{1'b1}} : sum[TW-1:0];
    assign err_now   = r_error_seen || bad;
    assign total_ext = 32'(sat_total);

    always_comb begin
        o_result = '0;
        if (!bad) begin
            o_result.byte_0 = {v0, v1[4:2]};
            o_result.byte_1 = {v1[1:0], v2, v3[4]};
            o_result.byte_2 = {v3[3:0], v4[4:1]};
            o_result.byte_3 = {v4[0], v5, v6[4:3]};
            o_result.byte_4 = {v6[2:0], v7};
        end
        o_result.valid_bytes   = nvalid;
        o_result.group_error   = bad;
        o_result.message_bytes = err_now ? '0 : total_ext[b32gd_pkg::MSG_WIDTH-1:0];
        o_result.message_error = err_now;
    end

    // A message ends on its last group, which clears the running state.
    always_comb begin
        n_total      = r_total;
        n_error_seen = r_error_seen;
        if (i_accept) begin
            if (i_last_group) begin
                n_total      = '0;
                n_error_seen = 1'b0;
            end else begin
                n_total      = sat_total;
                n_error_seen = err_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total      <= '0;
            r_error_seen <= 1'b0;
        end else begin
            r_total      <= n_total;
            r_error_seen <= n_error_seen;
        end
    end

endmodule

@@ design/base32_group_decoder.sv @@
// ----------------------------------------------------------------------------
// base32_group_decoder
// Decodes one group of eight Base32 characters per request into five bytes.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (i_valid, o_stall, i_data) carries one request per group
// of eight ASCII codes plus a last_group mark that closes the message. The
// output channel (o_valid, i_stall, o_data) returns one result per request:
// the five decoded bytes, how many are meaningful, the group error flag, and
// the running message byte total with its sticky error.
// An accepted request enters the output register, or the skid register if a
// stalled result holds it. Eight lanes decode side by side and a merge stage
// packs bytes and updates the total, one group per cycle unless stalled.
// The output register is backed by a one-entry skid register, so o_stall is
// a registered signal and a request can be accepted in the same cycle that a
// result waits on a stalled receiver. The input channel stalls only while
// the skid register is full, that is, after two results are pending.
// Synchronous active-low reset clears the message total, the error flag and
// both valid bits; no result is presented until a new request arrives.
// ----------------------------------------------------------------------------
module base32_group_decoder (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  b32gd_pkg::t_in_req   i_data,
    output logic                 o_valid,
    input  logic                 i_stall,
    output b32gd_pkg::t_out_req  o_data
);

    b32gd_pkg::t_sym [b32gd_pkg::NUM_LANES-1:0] lane_syms;
    logic [b32gd_pkg::NUM_LANES-1:0][7:0]      lane_codes;
    b32gd_pkg::t_out_req                        result;

    logic                r_out_valid;
    logic                r_skid_valid;
    b32gd_pkg::t_out_req r_out;
    b32gd_pkg::t_out_req r_skid;
    logic                n_out_valid;
    logic                n_skid_valid;
    b32gd_pkg::t_out_req n_out;
    b32gd_pkg::t_out_req n_skid;

    logic in_accept;
    logic out_take;

    assign lane_codes[0] = i_data.char_0;
    assign lane_codes[1] = i_data.char_1;
    assign lane_codes[2] = i_data.char_2;
    assign lane_codes[3] = i_data.char_3;
    assign lane_codes[4] = i_data.char_4;
    assign lane_codes[5] = i_data.char_5;
    assign lane_codes[6] = i_data.char_6;
    assign lane_codes[7] = i_data.char_7;

    // One classifier lane per character position.
    for (genvar g = 0; g < b32gd_pkg::NUM_LANES; g++) begin : g_lane
        b32gd_lane u_lane (
            .i_code (lane_codes[g]),
            .o_sym  (lane_syms[g])
        );
    end

    assign in_accept = i_valid && !r_skid_valid;
    assign out_take  = r_out_valid && !i_stall;

    // The merge stage holds the message state and advances it on acceptance.
    b32gd_merge u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_accept),
        .i_syms       (lane_syms),
        .i_last_group (i_data.last_group),
        .o_result     (result)
    );

    // Output register with a skid entry behind it. The skid entry only fills
    // when a new result arrives while the output register is stalled, and it
    // drains into the output register as soon as the receiver takes a result.
    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (out_take) begin
            n_out_valid = 1'b0;
        end
        if (out_take && r_skid_valid) begin
            n_out        = r_skid;
            n_out_valid  = 1'b1;
            n_skid_valid = 1'b0;
        end else if (in_accept) begin
            if (!r_out_valid || out_take) begin
                n_out       = result;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = result;
                n_skid_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;
    assign o_stall = r_skid_valid;

endmodule

@@ design/b32gd_checker.sv @@
// ----------------------------------------------------------------------------
// b32gd_checker
// Port-level checks on the Base32 group decoder, bound to its top level.
// ----------------------------------------------------------------------------
`include "base32_group_decoder_assert.svh"

module b32gd_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_valid,
    input logic                 o_stall,
    input b32gd_pkg::t_in_req   i_data,
    input logic                 o_valid,
    input logic                 i_stall,
    input b32gd_pkg::t_out_req  o_data
);

    // A failed group never reports meaningful bytes.
    `B32GD_ASSERT_NOW(a_err_no_bytes, i_clk, i_rst_n, o_valid && o_data.group_error, o_data.valid_bytes == 3'd0 && o_data.byte_0 == 8'd0)

    // A failed group always marks its message as failed.
    `B32GD_ASSERT_NOW(a_err_sticky, i_clk, i_rst_n, o_valid && o_data.group_error, o_data.message_error)

    // A failed message reports no byte total.
    `B32GD_ASSERT_NOW(a_err_total, i_clk, i_rst_n, o_valid && o_data.message_error, o_data.message_bytes == '0)

    // A stalled result stays presented and unchanged.
    `B32GD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_data))

    // A stalled request stays offered and unchanged.
    `B32GD_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, i_valid && o_stall, i_valid && $stable(i_data))

endmodule

bind base32_group_decoder b32gd_checker u_b32gd_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .i_data  (i_data),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);

@@ test/tb_base32_group_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_base32_group_decoder
// Self-checking bench for the Base32 group decoder. Each accepted request is
// run through a local decode of the group and the message counters, and each
// result is compared field by field with the oldest expected result.
// ----------------------------------------------------------------------------
module tb_base32_group_decoder;

    localparam int LIMIT_NS = 2_000_000;

    localparam int TW = b32gd_pkg::TOTAL_WIDTH;
    localparam int MW = b32gd_pkg::MSG_WIDTH;

    localparam logic [7:0] ASCII_UPPER_A = 8'h41;
    localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
    localparam logic [7:0] ASCII_LOWER_A = 8'h61;
    localparam logic [7:0] ASCII_LOWER_Z = 8'h7A;
    localparam logic [7:0] ASCII_DIGIT_2 = 8'h32;
    localparam logic [7:0] ASCII_DIGIT_7 = 8'h37;
    localparam logic [7:0] DIGIT_BASE    = 8'd26;

    typedef enum logic [1:0] {
        CH_SYMBOL,
        CH_PADDING,
        CH_INVALID
    } t_char_kind;

    typedef logic [7:0] t_group_chars [8];

    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                i_stall = 1'b0;
    b32gd_pkg::t_in_req  i_data  = '0;
    logic                o_stall;
    logic                o_valid;
    b32gd_pkg::t_out_req o_data;

    // Local copy of the message counters, advanced at each accepted request.
    logic [TW-1:0] msg_total  = '0;
    logic          msg_failed = 1'b0;

    b32gd_pkg::t_out_req pending_decodes [$];
    int                  error_count = 0;

    // Random idling on both sides is on only while this is set.
    bit idle_en  = 1'b0;
    // A long receiver hold-off is requested here and counted down by the
    // receiver process itself.
    int hold_len   = 0;
    int stall_left = 0;

    base32_group_decoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Decode prediction
    // ------------------------------------------------------------------

    function automatic t_char_kind classify_char(input logic [7:0] code,
                                                 output logic [4:0] value);
        value = 5'd0;
        if (code >= ASCII_UPPER_A && code <= ASCII_UPPER_Z) begin
            value = 5'(code - ASCII_UPPER_A);
            return CH_SYMBOL;
        end
        if (code >= ASCII_LOWER_A && code <= ASCII_LOWER_Z) begin
            value = 5'(code - ASCII_LOWER_A);
            return CH_SYMBOL;
        end
        if (code >= ASCII_DIGIT_2 && code <= ASCII_DIGIT_7) begin
            value = 5'(code - ASCII_DIGIT_2 + DIGIT_BASE);
            return CH_SYMBOL;
        end
        if (code == b32gd_pkg::CODE_PAD) begin
            return CH_PADDING;
        end
        return CH_INVALID;
    endfunction

    // Decodes one group and advances the message counters, as the block does
    // for the request that carries it.
    function automatic b32gd_pkg::t_out_req decode_group(input b32gd_pkg::t_in_req grp);
        t_group_chars        chars;
        t_char_kind          kind [8];
        logic [4:0]          value [8];
        logic                bad;
        b32gd_pkg::t_out_req res;
        logic [TW:0]         sum;
        chars = '{grp.char_0, grp.char_1, grp.char_2, grp.char_3,
                  grp.char_4, grp.char_5, grp.char_6, grp.char_7};
        bad = 1'b0;
        res = '0;
        for (int i = 0; i < 8; i++) begin
            kind[i] = classify_char(chars[i], value[i]);
            // The first two places must hold real symbols; padding is not
            // allowed there.
            if (kind[i] == CH_INVALID || (i < 2 && kind[i] == CH_PADDING))
                bad = 1'b1;
        end
        if (!bad) begin
            // Forty bits, most significant symbol first, padding as zeros.
            {res.byte_0, res.byte_1, res.byte_2, res.byte_3, res.byte_4} =
                {value[0], value[1], value[2], value[3],
                 value[4], value[5], value[6], value[7]};
            res.valid_bytes = 3'd5;
            if (kind[7] == CH_PADDING) begin
                res.valid_bytes = 3'd4;
                if (kind[5] == CH_PADDING) begin
                    res.valid_bytes = 3'd3;
                    if (kind[4] == CH_PADDING) begin
                        res.valid_bytes = 3'd2;
                        if (kind[2] == CH_PADDING)
                            res.valid_bytes = 3'd1;
                    end
                end
            end
        end
        sum = {1'b0, msg_total} + (TW+1)'(res.valid_bytes);
        msg_total = sum[TW] ? '1 : sum[TW-1:0];
        if (bad)
            msg_failed = 1'b1;
        res.group_error   = bad;
        res.message_bytes = msg_failed ? '0 : MW'(msg_total);
        res.message_error = msg_failed;
        if (grp.last_group) begin
            msg_total  = '0;
            msg_failed = 1'b0;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Group construction
    // ------------------------------------------------------------------

    function automatic b32gd_pkg::t_in_req pack_group(input t_group_chars c,
                                                      input logic last);
        b32gd_pkg::t_in_req grp;
        grp.char_0     = c[0];
        grp.char_1     = c[1];
        grp.char_2     = c[2];
        grp.char_3     = c[3];
        grp.char_4     = c[4];
        grp.char_5     = c[5];
        grp.char_6     = c[6];
        grp.char_7     = c[7];
        grp.last_group = last;
        return grp;
    endfunction

    function automatic b32gd_pkg::t_in_req text_group(input string s, input logic last);
        t_group_chars c;
        for (int i = 0; i < 8; i++)
            c[i] = s[i];
        return pack_group(c, last);
    endfunction

    function automatic logic [7:0] random_symbol_char();
        case ($urandom_range(0, 2))
            0:       return ASCII_UPPER_A + 8'($urandom_range(0, 25));
            1:       return ASCII_LOWER_A + 8'($urandom_range(0, 25));
            default: return ASCII_DIGIT_2 + 8'($urandom_range(0, 5));
        endcase
    endfunction

    function automatic logic [7:0] random_invalid_char();
        logic [7:0] code;
        logic [4:0] unused;
        do
            code = 8'($urandom_range(0, 255));
        while (classify_char(code, unused) != CH_INVALID);
        return code;
    endfunction

    // Mostly well-formed groups with correct trailing padding, then groups
    // with padding in odd places, groups with bad characters, and raw noise.
    function automatic b32gd_pkg::t_in_req random_group();
        t_group_chars c;
        int           pick;
        int           pad_from;
        int           pos;
        pick = $urandom_range(0, 99);
        for (int i = 0; i < 8; i++)
            c[i] = random_symbol_char();
        if (pick < 70) begin
            case ($urandom_range(1, 5))
                1:       pad_from = 2;
                2:       pad_from = 4;
                3:       pad_from = 5;
                4:       pad_from = 7;
                default: pad_from = 8;
            endcase
            for (int i = 2; i < 8; i++)
                if (i >= pad_from)
                    c[i] = b32gd_pkg::CODE_PAD;
        end else if (pick < 80) begin
            for (int i = 2; i < 8; i++)
                if ($urandom_range(0, 2) == 0)
                    c[i] = b32gd_pkg::CODE_PAD;
        end else if (pick < 92) begin
            repeat ($urandom_range(1, 2)) begin
                pos = $urandom_range(0, 7);
                if (pos < 2 && $urandom_range(0, 3) == 0)
                    c[pos] = b32gd_pkg::CODE_PAD;
                else
                    c[pos] = random_invalid_char();
            end
        end else begin
            for (int i = 0; i < 8; i++)
                c[i] = 8'($urandom_range(0, 255));
        end
        return pack_group(c, $urandom_range(0, 7) == 0);
    endfunction

    // ------------------------------------------------------------------
    // Request driver, receiver and result checker
    // ------------------------------------------------------------------

    // Called just after a falling edge. Drops i_valid for the given number
    // of cycles; the caller raises it again for the next request.
    task automatic idle_sender(input int cycles);
        i_valid <= 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    task automatic send_group(input b32gd_pkg::t_in_req grp);
        if (idle_en && $urandom_range(0, 5) == 0)
            idle_sender($urandom_range(1, 3));
        i_valid <= 1'b1;
        i_data  <= grp;
        do @(posedge i_clk); while (o_stall);
        pending_decodes.push_back(decode_group(grp));
        @(negedge i_clk);
    endtask

    task automatic wait_all_results();
        i_valid <= 1'b0;
        while (pending_decodes.size() != 0)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        if (hold_len > 0) begin
            stall_left = hold_len;
            hold_len   = 0;
        end
        if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left--;
        end else if (idle_en && $urandom_range(0, 7) == 0) begin
            i_stall <= 1'b1;
            stall_left = int'($urandom_range(0, 2));
        end else begin
            i_stall <= 1'b0;
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        b32gd_pkg::t_out_req want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_decodes.size() == 0) begin
                $error("result with no request outstanding");
                error_count++;
            end else begin
                want = pending_decodes.pop_front();
                check_field("byte_0", 32'(want.byte_0), 32'(o_data.byte_0));
                check_field("byte_1", 32'(want.byte_1), 32'(o_data.byte_1));
                check_field("byte_2", 32'(want.byte_2), 32'(o_data.byte_2));
                check_field("byte_3", 32'(want.byte_3), 32'(o_data.byte_3));
                check_field("byte_4", 32'(want.byte_4), 32'(o_data.byte_4));
                check_field("valid_bytes", 32'(want.valid_bytes),
                            32'(o_data.valid_bytes));
                check_field("group_error", 32'(want.group_error),
                            32'(o_data.group_error));
                check_field("message_bytes", 32'(want.message_bytes),
                            32'(o_data.message_bytes));
                check_field("message_error", 32'(want.message_error),
                            32'(o_data.message_error));
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Both ends of each symbol range, upper and lower case.
    task automatic test_symbol_extremes();
        send_group(text_group("AAAAAAAA", 1'b0));
        send_group(text_group("ZZZZZZZZ", 1'b0));
        send_group(text_group("aaaaaaaa", 1'b0));
        send_group(text_group("zzzzzzzz", 1'b0));
        send_group(text_group("22222222", 1'b0));
        send_group(text_group("77777777", 1'b0));
        send_group(text_group("MZXW6ytb", 1'b1));
    endtask

    // Each length of trailing padding, then padding in places that the
    // nested rule ignores.
    task automatic test_padding_rule();
        send_group(text_group("MY======", 1'b0));
        send_group(text_group("MZXQ====", 1'b0));
        send_group(text_group("MZXW6===", 1'b0));
        send_group(text_group("MZXW6YQ=", 1'b0));
        send_group(text_group("AB=CDEFG", 1'b0));
        send_group(text_group("AB=====7", 1'b0));
        send_group(text_group("ABCD=F==", 1'b1));
    endtask

    // Codes just outside each symbol range, high codes, and padding in the
    // first two places. The error sticks until the message ends.
    task automatic test_group_errors();
        b32gd_pkg::t_in_req grp;
        send_group(text_group("MZXW6YTB", 1'b0));
        grp = text_group("AAAAAAAA", 1'b0);
        grp.char_3 = 8'h80;
        send_group(grp);
        send_group(text_group("MZXW6YTB", 1'b0));
        grp = text_group("AAAAAAAA", 1'b0);
        grp.char_7 = 8'hFF;
        send_group(grp);
        grp = text_group("AAAAAAAA", 1'b0);
        grp.char_0 = 8'h00;
        send_group(grp);
        send_group(text_group("=AAAAAAA", 1'b0));
        send_group(text_group("A=AAAAAA", 1'b0));
        send_group(text_group("AAA1AAAA", 1'b0));
        send_group(text_group("AAAA8AAA", 1'b0));
        send_group(text_group("AAAAA@A[", 1'b0));
        send_group(text_group("A`{AAAAA", 1'b1));
        send_group(text_group("MZXW6YQ=", 1'b1));
    endtask

    // One long message, mostly of full groups, keeps the byte total climbing.
    task automatic test_long_message();
        t_group_chars c;
        for (int n = 0; n < 30; n++) begin
            for (int i = 0; i < 8; i++)
                c[i] = random_symbol_char();
            send_group(pack_group(c, 1'b0));
        end
        send_group(text_group("MY======", 1'b0));
        send_group(text_group("MZXW6YTB", 1'b1));
    endtask

    task automatic test_random_groups();
        idle_en = 1'b1;
        repeat (900)
            send_group(random_group());
    endtask

    // The receiver holds off long enough for the block to fill and stall
    // its input while requests keep coming.
    task automatic test_receiver_hold();
        i_valid <= 1'b0;
        @(posedge i_clk);
        hold_len = 150;
        @(negedge i_clk);
        repeat (50)
            send_group(random_group());
    endtask

    // The sender stops until every result is back, then carries on.
    task automatic test_sender_drain();
        repeat (4) begin
            repeat (25)
                send_group(random_group());
            wait_all_results();
        end
    endtask

    // Final stretch at full rate on both sides.
    task automatic test_streaming();
        idle_en = 1'b0;
        repeat (600)
            send_group(random_group());
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_symbol_extremes();
        test_padding_rule();
        test_group_errors();
        test_long_message();
        test_random_groups();
        test_receiver_hold();
        test_sender_drain();
        test_streaming();

        wait_all_results();
        repeat (8) @(posedge i_clk);
        if (error_count == 0)
            $display("[base32_group_decoder] OK");
        else
            $display("[base32_group_decoder] ERROR");
        $finish;
    end

    initial begin
        #(LIMIT_NS);
        $display("[base32_group_decoder] ERROR");
        $finish;
    end

endmodule
